### sv/brpd_pkg.sv
// ----------------------------------------------------------------------------
// brpd_pkg: shared types and constants for the BMP RLE palette decoder
// Item layouts, queue entry layout, register indexes and status codes.
// ----------------------------------------------------------------------------
package brpd_pkg;

  localparam int MAX_WIDTH     = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int PALETTE_DEPTH = 256;

  localparam int DIM_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int FQ_DEPTH  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_INDICES = 2'd2;

  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_DATA    = 1'b1;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_EOI   = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  // second byte of an escape pair
  localparam logic [7:0] MK_EOL   = 8'd0;
  localparam logic [7:0] MK_EOI   = 8'd1;
  localparam logic [7:0] MK_DELTA = 8'd2;

  localparam logic [3:0] LOW_NIBBLE = 4'hF;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  palette_index;
    logic [31:0] palette_color;
    logic [7:0]  data_byte;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic        span_valid;
    logic [11:0] span_row;
    logic [11:0] span_col;
    logic [12:0] span_count;
    logic [31:0] color_even;
    logic [31:0] color_odd;
    logic [1:0]  status;
  } out_item_t;

  // one queued job: a palette write, or a result whose colors are still indexes
  typedef struct packed {
    logic        is_write;
    logic        span_valid;
    logic [11:0] span_row;
    logic [11:0] span_col;
    logic [12:0] span_count;
    logic [7:0]  idx_even;
    logic [7:0]  idx_odd;
    logic [1:0]  status;
    logic [31:0] color;
  } fq_entry_t;

  typedef struct packed {
    logic      push;
    fq_entry_t entry;
  } fq_push_t;

endpackage

### sv/bmp_rle_palette_decoder.sv
// ----------------------------------------------------------------------------
// bmp_rle_palette_decoder: BMP RLE8/RLE4 stream to palette color spans
// Front parser, job queue and palette/result back end.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low: palette writes and compressed
// bytes alike. Each item gives at most one result; a result passes the queue,
// the palette read register and the output register. While out_stall is low,
// the back end moves one queued job per cycle through the single write and two
// read ports of the palette memory, which sets the sustained rate of one item
// per cycle. Palette entries read as zero until written after reset.
// Configuration must be written only while the block is idle (not enforced).
module bmp_rle_palette_decoder import brpd_pkg::*; #(
  parameter int PAL_DEPTH = PALETTE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item
);

  fq_push_t  fq_push;
  fq_entry_t fq_head;
  logic      fq_full, fq_empty, fq_pop;

  brpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .fq_full   (fq_full),
    .fq_push   (fq_push)
  );

  brpd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_in (fq_push),
    .full    (fq_full),
    .pop     (fq_pop),
    .empty   (fq_empty),
    .head    (fq_head)
  );

  brpd_back #(
    .PAL_DEPTH (PAL_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fq_empty  (fq_empty),
    .fq_head   (fq_head),
    .fq_pop    (fq_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### sv/brpd_fifo.sv
// ----------------------------------------------------------------------------
// brpd_fifo: job queue between front and back
// Small register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module brpd_fifo import brpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  fq_push_t  push_in,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output fq_entry_t head
);

  localparam int PTR_W = $clog2(FQ_DEPTH);
  localparam int CNT_W = $clog2(FQ_DEPTH + 1);

  fq_entry_t mem_r [FQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(FQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push_in.push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_in.entry;
    end
  end

endmodule

### sv/brpd_front.sv
// ----------------------------------------------------------------------------
// brpd_front: stream parser
// Holds the config registers and the RLE decode state; turns each accepted
// item into at most one queued job (palette write or result with indexes).
// ----------------------------------------------------------------------------
module brpd_front import brpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  input  logic                 fq_full,
  output fq_push_t             fq_push
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_ABS    = 2'd2;
  localparam logic [1:0] PH_PAD    = 2'd3;

  logic [DIM_W-1:0] width_cfg_r, height_cfg_r;
  logic             nibble_r;

  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [7:0]       abs_r, abs_nxt;
  logic             pad_r, pad_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic             err_r, err_nxt;

  logic [DIM_W-1:0] w_eff, h_eff, room, cnt;
  logic [DIM_W:0]   abs_end;
  logic [8:0]       b_inc;
  logic [7:0]       b;
  logic [7:0]       ie, io;
  logic [1:0]       st;
  logic             sv, err, acc;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > maxv) begin
      r = DIM_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign w_eff    = clamp_dim(width_cfg_r, MAX_WIDTH);
  assign h_eff    = clamp_dim(height_cfg_r, MAX_HEIGHT);
  assign in_stall = fq_full;
  assign acc      = in_valid && !in_stall;
  assign b        = in_item.data_byte;
  assign room     = (col_r < w_eff) ? w_eff - col_r : '0;
  assign abs_end  = {1'b0, col_r} + (DIM_W + 1)'(b);
  assign b_inc    = {1'b0, b} + 9'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= DIM_W'(1);
      height_cfg_r <= DIM_W'(1);
      nibble_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:    width_cfg_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT:   height_cfg_r <= cfg_wdata;
        CFG_NIBBLE_INDICES: nibble_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    abs_nxt   = abs_r;
    pad_nxt   = pad_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    err_nxt   = err_r;
    sv        = 1'b0;
    cnt       = '0;
    ie        = '0;
    io        = '0;
    st        = ST_NONE;
    err       = 1'b0;
    fq_push   = '0;

    if (acc) begin
      if (in_item.cmd == CMD_PALETTE) begin
        fq_push.push           = 1'b1;
        fq_push.entry.is_write = 1'b1;
        fq_push.entry.idx_even = in_item.palette_index;
        fq_push.entry.color    = in_item.palette_color;
      end else if (err_r) begin
        if (in_item.last_byte) begin
          phase_nxt = PH_FIRST;
          held_nxt  = '0;
          abs_nxt   = '0;
          pad_nxt   = 1'b0;
          row_nxt   = '0;
          col_nxt   = '0;
          err_nxt   = 1'b0;
        end
      end else begin
        unique case (phase_r)
          PH_FIRST: begin
            held_nxt  = b;
            phase_nxt = PH_SECOND;
          end
          PH_SECOND: begin
            phase_nxt = PH_FIRST;
            if (held_r != '0) begin
              // encoded run, clamped to what is left of the row
              if (row_r >= h_eff) begin
                err = 1'b1;
              end else begin
                cnt = (DIM_W'(held_r) < room) ? DIM_W'(held_r) : room;
                if (cnt != '0) begin
                  sv      = 1'b1;
                  col_nxt = col_r + cnt;
                  if (nibble_r) begin
                    ie = {4'b0, b[7:4]};
                    io = (cnt >= DIM_W'(2)) ? {4'b0, b[3:0] & LOW_NIBBLE} : ie;
                  end else begin
                    ie = b;
                    io = b;
                  end
                end
              end
            end else if (b == MK_EOL) begin
              if (row_r >= h_eff) begin
                err = 1'b1;
              end else begin
                if (col_r < w_eff) begin
                  sv  = 1'b1;
                  cnt = room;
                end
                col_nxt = '0;
                row_nxt = row_r + 1'b1;
              end
            end else if (b == MK_EOI) begin
              if (row_r == h_eff - 1'b1 || row_r == h_eff) begin
                st = ST_EOI;
              end else begin
                err = 1'b1;
              end
            end else if (b == MK_DELTA) begin
              err = 1'b1;
            end else begin
              if (row_r >= h_eff || abs_end > {1'b0, w_eff}) begin
                err = 1'b1;
              end else begin
                abs_nxt   = b;
                pad_nxt   = nibble_r ? b_inc[1] : b[0];
                phase_nxt = PH_ABS;
              end
            end
          end
          PH_ABS: begin
            if (abs_r == '0) begin
              phase_nxt = PH_FIRST;
            end else begin
              sv = 1'b1;
              if (nibble_r) begin
                cnt = (abs_r >= 8'd2) ? DIM_W'(2) : DIM_W'(1);
                ie  = {4'b0, b[7:4]};
                io  = (abs_r >= 8'd2) ? {4'b0, b[3:0] & LOW_NIBBLE} : ie;
              end else begin
                cnt = DIM_W'(1);
                ie  = b;
                io  = b;
              end
              col_nxt = col_r + cnt;
              abs_nxt = abs_r - 8'(cnt);
              if (abs_nxt == '0) begin
                phase_nxt = pad_r ? PH_PAD : PH_FIRST;
              end
            end
          end
          PH_PAD: begin
            pad_nxt   = 1'b0;
            phase_nxt = PH_FIRST;
          end
        endcase

        if (err) begin
          sv      = 1'b0;
          cnt     = '0;
          st      = ST_ERROR;
          err_nxt = 1'b1;
        end
        if (in_item.last_byte) begin
          if (!err) begin
            st = (phase_nxt != PH_FIRST) ? ST_ERROR : ST_DONE;
          end
          phase_nxt = PH_FIRST;
          held_nxt  = '0;
          abs_nxt   = '0;
          pad_nxt   = 1'b0;
          row_nxt   = '0;
          col_nxt   = '0;
          err_nxt   = 1'b0;
        end

        fq_push.push             = sv || (st != ST_NONE);
        fq_push.entry.span_valid = sv;
        fq_push.entry.span_row   = sv ? row_r[11:0] : '0;
        fq_push.entry.span_col   = sv ? col_r[11:0] : '0;
        fq_push.entry.span_count = cnt;
        fq_push.entry.idx_even   = ie;
        fq_push.entry.idx_odd    = io;
        fq_push.entry.status     = st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      held_r  <= '0;
      abs_r   <= '0;
      pad_r   <= 1'b0;
      row_r   <= '0;
      col_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      abs_r   <= abs_nxt;
      pad_r   <= pad_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

### sv/brpd_back.sv
// ----------------------------------------------------------------------------
// brpd_back: palette and result stage
// Pops queued jobs in order: writes the palette memory, or reads two
// entries and presents the finished result in the output register.
// ----------------------------------------------------------------------------
module brpd_back import brpd_pkg::*; #(
  parameter int PAL_DEPTH = PALETTE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fq_empty,
  input  fq_entry_t fq_head,
  output logic      fq_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int AW = $clog2(PAL_DEPTH);

  logic [31:0]   pal_mem [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] pal_vld_r;

  fq_entry_t     s1_job_r;
  logic          s1_valid_r, s1_valid_nxt;
  logic [31:0]   rd_even_r, rd_odd_r;
  logic          ok_even_r, ok_odd_r;

  out_item_t     out_r;
  logic          out_valid_r, out_valid_nxt;

  logic          out_free, s1_free, s1_adv, pop_rd, pop_wr;
  logic          rng_even, rng_odd;
  logic [AW-1:0] addr_even, addr_odd;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign s1_free   = !s1_valid_r || out_free;
  assign fq_pop    = !fq_empty && (fq_head.is_write || s1_free);
  assign pop_wr    = fq_pop && fq_head.is_write;
  assign pop_rd    = fq_pop && !fq_head.is_write;

  // indexes beyond the palette read as color 0 and are never written
  assign rng_even  = {1'b0, fq_head.idx_even} < 9'(PAL_DEPTH);
  assign rng_odd   = {1'b0, fq_head.idx_odd} < 9'(PAL_DEPTH);
  assign addr_even = fq_head.idx_even[AW-1:0];
  assign addr_odd  = fq_head.idx_odd[AW-1:0];

  always_ff @(posedge clk) begin
    if (pop_wr && rng_even) begin
      pal_mem[addr_even] <= fq_head.color;
    end
    if (pop_rd) begin
      rd_even_r <= pal_mem[addr_even];
      rd_odd_r  <= pal_mem[addr_odd];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_vld_r <= '0;
    end else if (pop_wr && rng_even) begin
      pal_vld_r[addr_even] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_rd) begin
      s1_job_r  <= fq_head;
      ok_even_r <= fq_head.span_valid && rng_even && pal_vld_r[addr_even];
      ok_odd_r  <= fq_head.span_valid && rng_odd && pal_vld_r[addr_odd];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (pop_rd) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r.span_valid <= s1_job_r.span_valid;
      out_r.span_row   <= s1_job_r.span_row;
      out_r.span_col   <= s1_job_r.span_col;
      out_r.span_count <= s1_job_r.span_count;
      out_r.color_even <= ok_even_r ? rd_even_r : '0;
      out_r.color_odd  <= ok_odd_r ? rd_odd_r : '0;
      out_r.status     <= s1_job_r.status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
